// File: hdl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, codes and lookup functions for the infix-to-postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  // Expression bytes with a meaning of their own
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_POW    = 8'h5E;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Stack entry codes
  localparam logic [2:0] OP_LPAREN = 3'd0;
  localparam logic [2:0] OP_POW    = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_DIV    = 3'd3;
  localparam logic [2:0] OP_ADD    = 3'd4;
  localparam logic [2:0] OP_SUB    = 3'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [2:0] op_code_t;
  typedef logic [1:0] prec_t;

  typedef enum logic [2:0] {
    CMD_SKIP,
    CMD_OPERAND,
    CMD_LPAREN,
    CMD_RPAREN,
    CMD_OPER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    op_code_t   code;
    logic [7:0] ch;
    logic       fin;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_CMD,
    BK_RPAR,
    BK_OPER,
    BK_FLUSH,
    BK_FIN
  } back_state_t;

  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] ch;
    unique case (code)
      OP_LPAREN: ch = CH_LPAREN;
      OP_POW:    ch = CH_POW;
      OP_MUL:    ch = CH_MUL;
      OP_DIV:    ch = CH_DIV;
      OP_ADD:    ch = CH_ADD;
      OP_SUB:    ch = CH_SUB;
      default:   ch = CH_LPAREN;
    endcase
    return ch;
  endfunction

  function automatic prec_t op_prec(input op_code_t code);
    prec_t p;
    unique case (code)
      OP_POW:                  p = 2'd3;
      OP_MUL, OP_DIV:          p = 2'd2;
      OP_ADD, OP_SUB:          p = 2'd1;
      default:                 p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// File: hdl/i2p_if.sv
// ----------------------------------------------------------------------------
// i2p_if
// Valid/ready channels for expression bytes in and postfix bytes out.
// ----------------------------------------------------------------------------
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_expr;

  modport source (output valid, output char_code, output end_of_expr, input ready);
  modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       empty_end;
  logic       overflow;

  modport source (output valid, output out_char, output last, output empty_end,
                  output overflow, input ready);
  modport sink   (input valid, input out_char, input last, input empty_end,
                  input overflow, output ready);
endinterface

// File: hdl/i2p_front.sv
// ----------------------------------------------------------------------------
// i2p_front
// Accepts expression bytes and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module i2p_front (
  i2p_in_if.sink         expr,
  input  logic           q_full,
  output logic           q_push,
  output i2p_pkg::cmd_t  q_data
);

  assign expr.ready = !q_full;
  assign q_push     = expr.valid && !q_full;

  always_comb begin
    q_data.ch   = expr.char_code;
    q_data.fin  = expr.end_of_expr;
    q_data.code = i2p_pkg::OP_LPAREN;
    q_data.kind = i2p_pkg::CMD_OPERAND;
    unique case (expr.char_code)
      i2p_pkg::CH_SPACE:  q_data.kind = i2p_pkg::CMD_SKIP;
      i2p_pkg::CH_LPAREN: q_data.kind = i2p_pkg::CMD_LPAREN;
      i2p_pkg::CH_RPAREN: q_data.kind = i2p_pkg::CMD_RPAREN;
      i2p_pkg::CH_POW: begin
        q_data.kind = i2p_pkg::CMD_OPER;
        q_data.code = i2p_pkg::OP_POW;
      end
      i2p_pkg::CH_MUL: begin
        q_data.kind = i2p_pkg::CMD_OPER;
        q_data.code = i2p_pkg::OP_MUL;
      end
      i2p_pkg::CH_DIV: begin
        q_data.kind = i2p_pkg::CMD_OPER;
        q_data.code = i2p_pkg::OP_DIV;
      end
      i2p_pkg::CH_ADD: begin
        q_data.kind = i2p_pkg::CMD_OPER;
        q_data.code = i2p_pkg::OP_ADD;
      end
      i2p_pkg::CH_SUB: begin
        q_data.kind = i2p_pkg::CMD_OPER;
        q_data.code = i2p_pkg::OP_SUB;
      end
      default: q_data.kind = i2p_pkg::CMD_OPERAND;
    endcase
  end

endmodule

// File: hdl/i2p_queue.sv
// ----------------------------------------------------------------------------
// i2p_queue
// Short command queue between the classifier and the stack sequencer.
// ----------------------------------------------------------------------------
module i2p_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  i2p_pkg::cmd_t  push_data,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output i2p_pkg::cmd_t  head
);

  i2p_pkg::cmd_t                  entries [i2p_pkg::QUEUE_DEPTH];
  logic [i2p_pkg::QPTR_W-1:0]     wr_ptr;
  logic [i2p_pkg::QPTR_W-1:0]     rd_ptr;
  logic [i2p_pkg::QCNT_W-1:0]     fill;

  localparam logic [i2p_pkg::QPTR_W-1:0] PTR_LAST = i2p_pkg::QPTR_W'(i2p_pkg::QUEUE_DEPTH - 1);
  localparam logic [i2p_pkg::QCNT_W-1:0] FILL_MAX = i2p_pkg::QCNT_W'(i2p_pkg::QUEUE_DEPTH);

  assign full  = (fill == FILL_MAX);
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: hdl/i2p_back.sv
// ----------------------------------------------------------------------------
// i2p_back
// Operator stack sequencer: one stack access and at most one result a cycle.
// ----------------------------------------------------------------------------
module i2p_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  i2p_pkg::cmd_t  head,
  output logic           q_pop,
  i2p_out_if.source      postfix
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  i2p_pkg::back_state_t  state, state_next;

  logic [2:0]       stack_mem [STACK_DEPTH];
  logic [2:0]       top;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_en;
  logic             overflow_seen;

  // Newest byte of the end request is held back until we know whether it is
  // the last one; bytes of other requests go straight to the output register
  logic             pend_valid;
  logic [7:0]       pend_char;

  logic             ovalid;
  logic [7:0]       ochar;
  logic             olast, oempty, oovf;

  logic             out_free, can_emit, must_pop, cmd_done;
  logic             do_emit, do_pop, do_push, finish;
  logic             out_load;
  logic [7:0]       load_ch;
  logic [7:0]       emit_ch;
  logic [2:0]       push_code;

  assign out_free = !ovalid || postfix.ready;
  assign can_emit = (head.fin && !pend_valid) || out_free;

  assign must_pop = (count != '0) && (top != i2p_pkg::OP_LPAREN) &&
                    ((i2p_pkg::op_prec(top) > i2p_pkg::op_prec(head.code)) ||
                     ((i2p_pkg::op_prec(top) == i2p_pkg::op_prec(head.code)) &&
                      (head.code != i2p_pkg::OP_POW)));

  always_comb begin
    state_next = state;
    do_emit    = 1'b0;
    emit_ch    = head.ch;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    push_code  = head.code;
    q_pop      = 1'b0;
    finish     = 1'b0;
    cmd_done   = 1'b0;
    unique case (state)
      i2p_pkg::BK_CMD: begin
        if (!q_empty) begin
          unique case (head.kind)
            i2p_pkg::CMD_SKIP: cmd_done = 1'b1;
            i2p_pkg::CMD_OPERAND: begin
              if (can_emit) begin
                do_emit  = 1'b1;
                cmd_done = 1'b1;
              end
            end
            i2p_pkg::CMD_LPAREN: begin
              do_push   = 1'b1;
              push_code = i2p_pkg::OP_LPAREN;
              cmd_done  = 1'b1;
            end
            i2p_pkg::CMD_RPAREN: state_next = i2p_pkg::BK_RPAR;
            i2p_pkg::CMD_OPER:   state_next = i2p_pkg::BK_OPER;
            default:             state_next = i2p_pkg::BK_CMD;
          endcase
        end
      end
      i2p_pkg::BK_RPAR: begin
        if (count == '0) begin
          cmd_done = 1'b1;
        end else if (top == i2p_pkg::OP_LPAREN) begin
          do_pop   = 1'b1;
          cmd_done = 1'b1;
        end else if (can_emit) begin
          do_emit = 1'b1;
          emit_ch = i2p_pkg::op_char(top);
          do_pop  = 1'b1;
        end
      end
      i2p_pkg::BK_OPER: begin
        if (must_pop) begin
          if (can_emit) begin
            do_emit = 1'b1;
            emit_ch = i2p_pkg::op_char(top);
            do_pop  = 1'b1;
          end
        end else begin
          do_push  = 1'b1;
          cmd_done = 1'b1;
        end
      end
      i2p_pkg::BK_FLUSH: begin
        if (count == '0) begin
          state_next = i2p_pkg::BK_FIN;
        end else if (can_emit) begin
          do_emit = 1'b1;
          emit_ch = i2p_pkg::op_char(top);
          do_pop  = 1'b1;
        end
      end
      i2p_pkg::BK_FIN: begin
        if (out_free) begin
          finish     = 1'b1;
          q_pop      = 1'b1;
          state_next = i2p_pkg::BK_CMD;
        end
      end
      default: state_next = i2p_pkg::BK_CMD;
    endcase
    if (cmd_done) begin
      if (head.fin) begin
        state_next = i2p_pkg::BK_FLUSH;
      end else begin
        q_pop      = 1'b1;
        state_next = i2p_pkg::BK_CMD;
      end
    end
  end

  // Stack pointer and memory; read port always tracks the next top entry
  assign wr_en  = do_push && (count != CNT_FULL);
  assign wr_idx = count[IDX_W-1:0];

  always_comb begin
    count_next = count;
    if (wr_en) begin
      count_next = count + 1'b1;
    end else if (do_pop) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    logic [CNT_W-1:0] below;
    below  = count_next - 1'b1;
    rd_idx = (count_next == '0) ? '0 : below[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_idx] <= push_code;
    end
    top <= (wr_en && (wr_idx == rd_idx)) ? push_code : stack_mem[rd_idx];
  end

  // Output register load: direct bytes, or the held byte of the end request
  assign out_load = do_emit && (pend_valid || !head.fin);
  assign load_ch  = head.fin ? pend_char : emit_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= i2p_pkg::BK_CMD;
      count         <= '0;
      overflow_seen <= 1'b0;
      pend_valid    <= 1'b0;
      ovalid        <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (do_push && (count == CNT_FULL)) begin
        overflow_seen <= 1'b1;
      end
      if (finish) begin
        overflow_seen <= 1'b0;
      end
      if (do_emit && head.fin) begin
        pend_valid <= 1'b1;
      end else if (finish) begin
        pend_valid <= 1'b0;
      end
      if (out_load || finish) begin
        ovalid <= 1'b1;
      end else if (postfix.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit && head.fin) begin
      pend_char <= emit_ch;
    end
    if (out_load) begin
      ochar  <= load_ch;
      olast  <= 1'b0;
      oempty <= 1'b0;
      oovf   <= 1'b0;
    end else if (finish) begin
      ochar  <= pend_valid ? pend_char : 8'h00;
      olast  <= 1'b1;
      oempty <= !pend_valid;
      oovf   <= overflow_seen;
    end
  end

  assign postfix.valid     = ovalid;
  assign postfix.out_char  = ochar;
  assign postfix.last      = olast;
  assign postfix.empty_end = oempty;
  assign postfix.overflow  = oovf;

endmodule

// File: hdl/infix_to_postfix_converter_top.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter from infix expression bytes to postfix bytes.
// ----------------------------------------------------------------------------
// Bytes are classified on entry and queued (two deep) for a stack sequencer
// that does at most one stack push or pop per clock. A space, operand or '('
// is handled at once; ')' emits operators until its '(' is popped, an operator
// pops those it displaces before it is pushed, and the end byte flushes the
// stack and closes with the marked final result. Results of the end byte are
// delayed by one emission so the final one can carry the last mark; output
// back-pressure stalls the sequencer only when its single output register is
// still full. The stack holds STACK_DEPTH entries (at least 2); a push onto a
// full stack is dropped and reported on the final result.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  i2p_in_if.sink     expr,
  i2p_out_if.source  postfix
);

  logic           q_full, q_empty, q_push, q_pop;
  i2p_pkg::cmd_t  q_data, q_head;

  i2p_front u_front (
    .expr   (expr),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  i2p_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (q_head),
    .q_pop   (q_pop),
    .postfix (postfix)
  );

endmodule

// File: hdl/i2p_checker.sv
// ----------------------------------------------------------------------------
// i2p_checker
// Port-level checks on the postfix result stream.
// ----------------------------------------------------------------------------
module i2p_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last,
  input logic       empty_end,
  input logic       overflow
);

  // A stalled request stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("postfix request dropped while stalled");

  // An empty end result is a bare marker
  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_end |-> last && (out_char == 8'h00))
    else $error("empty end result without last mark or with data");

  // Overflow is reported only with the expression's final result
  a_ovf_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> last)
    else $error("overflow flagged on a result that is not last");

endmodule

bind infix_to_postfix_converter_top i2p_checker u_i2p_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (postfix.valid),
  .out_ready (postfix.ready),
  .out_char  (postfix.out_char),
  .last      (postfix.last),
  .empty_end (postfix.empty_end),
  .overflow  (postfix.overflow)
);

// File: tb/tb_infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter_top
// Self-checking testbench for the shunting-yard infix-to-postfix converter.
// ----------------------------------------------------------------------------
// Expression bytes go in over the request channel with random gaps. A local
// operator stack predicts every postfix byte, its end mark and the overflow
// flag. Each result is checked in order as it arrives, under random
// back-pressure. Directed tests cover precedence, associativity, parenthesis
// corner cases and stack overflow. The random tests send mostly well-formed
// expressions, plus noise bytes and deep nesting.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter_top;

  localparam int                STACK_DEPTH = 16;
  localparam int                IDLE_LIMIT  = 1000;
  localparam int                DRAIN_WAIT  = 40;
  localparam int                RANDOM_REQS = 170;
  localparam i2p_pkg::op_code_t NOT_AN_OP   = 3'd7;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty_end;
    logic       overflow;
  } postfix_res_t;

  logic clk = 1'b0;
  logic rst;

  i2p_in_if  expr ();
  i2p_out_if postfix ();

  infix_to_postfix_converter_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .expr    (expr),
    .postfix (postfix)
  );

  always #2 clk = ~clk;

  // Predictor state
  i2p_pkg::op_code_t opstk [STACK_DEPTH];
  int           stk_cnt = 0;
  bit           ovf_seen = 1'b0;
  postfix_res_t pending_q [$];
  postfix_res_t held_res;
  bit           held_valid = 1'b0;
  int           step_count;

  // Stimulus buffer for one expression, end mark goes on its last byte
  logic [7:0]   expr_buf [$];
  bit           no_idle = 1'b0;

  int errors = 0;
  int reqs_sent = 0;
  int exprs_sent = 0;
  int results_seen = 0;
  int ovf_ends = 0;
  int empty_ends = 0;
  int idle_cycles = 0;

  const logic [7:0] oper_chars [5] = '{i2p_pkg::CH_POW, i2p_pkg::CH_MUL, i2p_pkg::CH_DIV,
                                       i2p_pkg::CH_ADD, i2p_pkg::CH_SUB};

  function automatic i2p_pkg::op_code_t classify(input logic [7:0] c);
    case (c)
      i2p_pkg::CH_LPAREN: return i2p_pkg::OP_LPAREN;
      i2p_pkg::CH_POW:    return i2p_pkg::OP_POW;
      i2p_pkg::CH_MUL:    return i2p_pkg::OP_MUL;
      i2p_pkg::CH_DIV:    return i2p_pkg::OP_DIV;
      i2p_pkg::CH_ADD:    return i2p_pkg::OP_ADD;
      i2p_pkg::CH_SUB:    return i2p_pkg::OP_SUB;
      default:            return NOT_AN_OP;
    endcase
  endfunction

  function automatic logic [7:0] symbol_of(input i2p_pkg::op_code_t k);
    case (k)
      i2p_pkg::OP_POW: return i2p_pkg::CH_POW;
      i2p_pkg::OP_MUL: return i2p_pkg::CH_MUL;
      i2p_pkg::OP_DIV: return i2p_pkg::CH_DIV;
      i2p_pkg::OP_ADD: return i2p_pkg::CH_ADD;
      i2p_pkg::OP_SUB: return i2p_pkg::CH_SUB;
      default:         return i2p_pkg::CH_LPAREN;
    endcase
  endfunction

  function automatic int binding(input i2p_pkg::op_code_t k);
    case (k)
      i2p_pkg::OP_POW:                  return 3;
      i2p_pkg::OP_MUL, i2p_pkg::OP_DIV: return 2;
      i2p_pkg::OP_ADD, i2p_pkg::OP_SUB: return 1;
      default:                          return 0;
    endcase
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (classify(c) != NOT_AN_OP || c == i2p_pkg::CH_SPACE || c == i2p_pkg::CH_RPAREN);
    return c;
  endfunction

  task automatic stack_push(input i2p_pkg::op_code_t k);
    if (stk_cnt >= STACK_DEPTH) begin
      ovf_seen = 1'b1;
    end else begin
      opstk[stk_cnt] = k;
      stk_cnt++;
    end
  endtask

  // Holds the newest result back so the end step can mark it
  task automatic emit_char(input logic [7:0] c);
    if (held_valid) pending_q.push_back(held_res);
    held_res.ch        = c;
    held_res.last      = 1'b0;
    held_res.empty_end = 1'b0;
    held_res.overflow  = 1'b0;
    held_valid = 1'b1;
    step_count++;
  endtask

  task automatic predict_postfix(input logic [7:0] c, input logic fin);
    i2p_pkg::op_code_t k;
    i2p_pkg::op_code_t t;
    step_count = 0;
    k = classify(c);
    if (c == i2p_pkg::CH_SPACE) begin
    end else if (c == i2p_pkg::CH_RPAREN) begin
      // unmatched ')' just empties the stack
      while (stk_cnt > 0) begin
        t = opstk[stk_cnt - 1];
        stk_cnt--;
        if (t == i2p_pkg::OP_LPAREN) break;
        emit_char(symbol_of(t));
      end
    end else if (k == i2p_pkg::OP_LPAREN) begin
      stack_push(k);
    end else if (k != NOT_AN_OP) begin
      while (stk_cnt > 0) begin
        t = opstk[stk_cnt - 1];
        if (t == i2p_pkg::OP_LPAREN) break;
        if (binding(t) > binding(k) ||
            (binding(t) == binding(k) && k != i2p_pkg::OP_POW)) begin
          emit_char(symbol_of(t));
          stk_cnt--;
        end else begin
          break;
        end
      end
      stack_push(k);
    end else begin
      emit_char(c);
    end

    if (fin) begin
      // stray '(' is flushed as a byte too
      while (stk_cnt > 0) begin
        emit_char(symbol_of(opstk[stk_cnt - 1]));
        stk_cnt--;
      end
      if (step_count == 0) begin
        emit_char(8'h00);
        held_res.empty_end = 1'b1;
      end
      held_res.last     = 1'b1;
      held_res.overflow = ovf_seen;
      ovf_seen = 1'b0;
    end
    if (held_valid) pending_q.push_back(held_res);
    held_valid = 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Entered and left at a falling edge
  task automatic send_byte(input logic [7:0] c, input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      expr.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    expr.valid       <= 1'b1;
    expr.char_code   <= c;
    expr.end_of_expr <= fin;
    do @(posedge clk); while (!expr.ready);
    predict_postfix(c, fin);
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < expr_buf.size(); i++)
      send_byte(expr_buf[i], i == expr_buf.size() - 1);
    expr_buf.delete();
    exprs_sent++;
  endtask

  // a^b^c*d/e-f+g with the byte extremes as first and last operand
  task automatic test_operator_precedence();
    expr_buf = '{8'h00, i2p_pkg::CH_POW, "b", i2p_pkg::CH_POW, "c", i2p_pkg::CH_MUL,
                 "d", i2p_pkg::CH_DIV, "e", i2p_pkg::CH_SUB, "f", i2p_pkg::CH_ADD,
                 8'hFF};
    send_buffer();
  endtask

  // matched pair, unmatched ')', stray '(' flushed by a space end, empty end
  task automatic test_paren_corner_cases();
    expr_buf = '{i2p_pkg::CH_LPAREN, "a", i2p_pkg::CH_ADD, "b", i2p_pkg::CH_RPAREN,
                 i2p_pkg::CH_RPAREN, i2p_pkg::CH_LPAREN, i2p_pkg::CH_SPACE};
    send_buffer();
    expr_buf = '{i2p_pkg::CH_RPAREN};
    send_buffer();
  endtask

  // one more '(' than the stack holds, then an operand end
  task automatic test_stack_overflow();
    repeat (STACK_DEPTH + 1) expr_buf.push_back(i2p_pkg::CH_LPAREN);
    expr_buf.push_back("x");
    send_buffer();
  endtask

  task automatic build_well_formed(input int terms);
    int depth_open;
    depth_open = 0;
    for (int i = 0; i < terms; i++) begin
      while ($urandom_range(0, 3) == 0 && depth_open < 6) begin
        expr_buf.push_back(i2p_pkg::CH_LPAREN);
        depth_open++;
      end
      expr_buf.push_back(rand_operand());
      while (depth_open > 0 && $urandom_range(0, 2) == 0) begin
        expr_buf.push_back(i2p_pkg::CH_RPAREN);
        depth_open--;
      end
      if (i != terms - 1) expr_buf.push_back(oper_chars[$urandom_range(0, 4)]);
      if ($urandom_range(0, 7) == 0) expr_buf.push_back(i2p_pkg::CH_SPACE);
    end
    if ($urandom_range(0, 1) == 0)
      while (depth_open > 0) begin
        expr_buf.push_back(i2p_pkg::CH_RPAREN);
        depth_open--;
      end
  endtask

  task automatic build_noise();
    int len;
    len = $urandom_range(1, 8);
    repeat (len) begin
      case ($urandom_range(0, 3))
        0: expr_buf.push_back(oper_chars[$urandom_range(0, 4)]);
        1: expr_buf.push_back($urandom_range(0, 1) ? i2p_pkg::CH_LPAREN
                                                   : i2p_pkg::CH_RPAREN);
        2: expr_buf.push_back($urandom_range(0, 1) ? i2p_pkg::CH_SPACE : 8'($urandom));
        default: expr_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic test_random_expressions();
    int target;
    int pick;
    target = reqs_sent + RANDOM_REQS;
    while (reqs_sent < target) begin
      no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // deep nesting, sometimes past the stack size
        repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4))
          expr_buf.push_back(i2p_pkg::CH_LPAREN);
        expr_buf.push_back(rand_operand());
        if ($urandom_range(0, 1)) expr_buf.push_back(oper_chars[$urandom_range(0, 4)]);
      end else if (pick <= 3) begin
        build_noise();
      end else begin
        build_well_formed($urandom_range(1, 6));
      end
      send_buffer();
    end
    no_idle = 1'b0;
  endtask

  // Result sink with random back-pressure
  initial begin : result_sink
    int stall;
    postfix.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        postfix.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      postfix.ready <= 1'b1;
      do @(posedge clk); while (!postfix.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    postfix_res_t want;
    if (!rst && postfix.valid && postfix.ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result out_char=%02h last=%b",
                                  postfix.out_char, postfix.last));
      end else begin
        want = pending_q.pop_front();
        if (want.overflow) ovf_ends++;
        if (want.empty_end) empty_ends++;
        if (postfix.out_char !== want.ch)
          report_mismatch($sformatf("out_char %02h, expected %02h",
                                    postfix.out_char, want.ch));
        if (postfix.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b (char %02h)",
                                    postfix.last, want.last, want.ch));
        if (postfix.empty_end !== want.empty_end)
          report_mismatch($sformatf("empty_end %b, expected %b",
                                    postfix.empty_end, want.empty_end));
        if (postfix.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, expected %b",
                                    postfix.overflow, want.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (expr.valid && expr.ready) || (postfix.valid && postfix.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    expr.valid       = 1'b0;
    expr.char_code   = 8'h00;
    expr.end_of_expr = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_operator_precedence();
    test_paren_corner_cases();
    test_stack_overflow();
    test_random_expressions();
    expr.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_q.size()));

    $display("Ran %0d expressions, %0d bytes in, %0d postfix results checked",
             exprs_sent, reqs_sent, results_seen);
    $display("Saw %0d overflowed ends and %0d empty ends, %0d mismatches",
             ovf_ends, empty_ends, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/i2p_pkg.sv
hdl/i2p_if.sv
hdl/i2p_front.sv
hdl/i2p_queue.sv
hdl/i2p_back.sv
hdl/infix_to_postfix_converter_top.sv
hdl/i2p_checker.sv
tb/tb_infix_to_postfix_converter_top.sv
